FILE: rtl/rprs_pkg.sv
package rprs_pkg;

	localparam int NODE_COUNT    = 8;
	localparam int TABLE_DEPTH   = 8;
	localparam int PAYLOAD_BYTES = 5;

	localparam logic [7:0] SLAVE_LISTEN_TICKS = 8'd200;
	localparam logic [7:0] SLAVE_SEND_TICKS   = 8'd3;

	localparam logic [7:0] SEND_TIMEOUT_RESET  = 8'd15;
	localparam logic [7:0] REPLY_TIMEOUT_RESET = 8'd20;

	typedef logic [PAYLOAD_BYTES-1:0][7:0] entry_t;

	typedef enum logic [2:0] {
		CMD_NONE       = 3'd0,
		CMD_TRANSMIT   = 3'd1,
		CMD_LISTEN     = 3'd2,
		CMD_RETRANSMIT = 3'd3,
		CMD_REINIT     = 3'd4,
		CMD_FETCH      = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TICK       = 2'd0,
		KIND_HOST_WRITE = 2'd1,
		KIND_HOST_READ  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_ROLE          = 2'd0,
		REG_OWN_NODE      = 2'd1,
		REG_SEND_TIMEOUT  = 2'd2,
		REG_REPLY_TIMEOUT = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_P0 = 4'b0001,
		PH_P1 = 4'b0010,
		PH_P2 = 4'b0100,
		PH_P3 = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       sent_done;
		logic       retry_exhausted;
		logic       reply_ready;
		logic [7:0] rx_byte_a;
		logic [7:0] rx_byte_b;
		logic [7:0] rx_byte_c;
		logic [7:0] rx_byte_d;
		logic [7:0] rx_byte_e;
		logic [2:0] table_node;
		logic [2:0] table_index;
		logic [7:0] table_value;
	} item_t;

	typedef struct packed {
		logic [2:0] radio_cmd;
		logic [2:0] target_node;
		logic [7:0] tx_byte_a;
		logic [7:0] tx_byte_b;
		logic [7:0] tx_byte_c;
		logic [7:0] tx_byte_d;
		logic [7:0] tx_byte_e;
		logic [7:0] read_data;
		logic       led_on;
	} result_t;

endpackage

FILE: rtl/rprs_item_if.sv
interface rprs_item_if;
	logic           valid;
	logic           ready;
	rprs_pkg::item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/rprs_result_if.sv
interface rprs_result_if;
	logic             valid;
	logic             ready;
	rprs_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/radio_poll_relay_sequencer_core.sv
// polled packet-radio link sequencer
// item channel (valid/ready): one beat is a radio tick, a host write of one
// transmit table byte, or a host read of one receive table byte
// result channel (valid/ready): exactly one beat per item, carrying the radio
// command, its node, the transmit payload, the read byte and the led state
// config port: cfg_wr_en with cfg_index and cfg_data writes one register
// (role, own node, send timeout, reply timeout) in the cycle it is high
// a beat taken is held in the input stage; its result is then registered
// throughput: one item per cycle while results are taken; the whole state
// update of an item is one pass of logic between the input stage and the
// result register
// a result waiting on a stalled receiver does not block the input stage, so
// one more item is taken; after that ready drops until the result is taken
// reset clears both payload tables, the sequencer state, the led and the
// registers to their defaults; timeouts return to 15 and 20 ticks
module radio_poll_relay_sequencer_core (
	input  logic                 clk,
	input  logic                 arst_n,
	rprs_item_if.sink            item,
	rprs_result_if.source        result,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data
);

	logic       role_q;
	logic [2:0] own_node_q;
	logic [7:0] send_to_q;
	logic [7:0] reply_to_q;

	rprs_pkg::phase_t phase_q, phase_d;
	logic [2:0]       node_q, node_d;
	logic [7:0]       wait_q, wait_d;
	logic             led_q, led_d;

	rprs_pkg::entry_t tx_q [rprs_pkg::TABLE_DEPTH];
	rprs_pkg::entry_t rx_q [rprs_pkg::TABLE_DEPTH];

	rprs_pkg::item_t   item_s1;
	logic              item_valid_s1;
	rprs_pkg::result_t res_q, res_d;
	logic              res_valid_q;
	logic              advance;

	logic             relay_en;
	logic             rx_wr_en;
	logic [2:0]       rx_wr_addr;
	logic             rx_clr;
	logic             host_wr;
	rprs_pkg::entry_t rx_entry;
	rprs_pkg::entry_t tx_sel;
	logic [7:0]       wait_inc;
	logic [3:0]       node_inc;
	logic [2:0]       next_node;

	assign advance      = item_valid_s1 && (!res_valid_q || result.ready);
	assign item.ready   = !item_valid_s1 || advance;
	assign result.valid = res_valid_q;
	assign result.payload = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q     <= 1'b0;
			own_node_q <= 3'd0;
			send_to_q  <= rprs_pkg::SEND_TIMEOUT_RESET;
			reply_to_q <= rprs_pkg::REPLY_TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rprs_pkg::REG_ROLE:          role_q     <= cfg_data[0];
				rprs_pkg::REG_OWN_NODE:      own_node_q <= cfg_data[2:0];
				rprs_pkg::REG_SEND_TIMEOUT:  send_to_q  <= cfg_data;
				rprs_pkg::REG_REPLY_TIMEOUT: reply_to_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
	end

	assign rx_entry = {item_s1.rx_byte_e, item_s1.rx_byte_d, item_s1.rx_byte_c,
		item_s1.rx_byte_b, item_s1.rx_byte_a};
	assign wait_inc  = wait_q + 8'd1;
	assign node_inc  = {1'b0, node_q} + 4'd1;
	assign next_node = (node_inc >= 4'(rprs_pkg::NODE_COUNT)) ? 3'd1 : node_inc[2:0];
	assign host_wr   = (item_s1.kind == rprs_pkg::KIND_HOST_WRITE)
		&& (item_s1.table_index < 3'(rprs_pkg::PAYLOAD_BYTES));

	always_comb begin
		phase_d    = phase_q;
		node_d     = node_q;
		wait_d     = wait_q;
		led_d      = led_q;
		relay_en   = 1'b0;
		rx_wr_en   = 1'b0;
		rx_wr_addr = 3'd0;
		rx_clr     = 1'b0;
		tx_sel     = '0;
		res_d      = '0;
		res_d.radio_cmd = rprs_pkg::CMD_NONE;

		if (item_s1.kind == rprs_pkg::KIND_TICK) begin
			if (!role_q) begin
				case (phase_q)
					rprs_pkg::PH_P0: begin
						node_d = next_node;
						tx_sel = tx_q[next_node];
						res_d.radio_cmd   = rprs_pkg::CMD_TRANSMIT;
						res_d.target_node = next_node;
						phase_d = rprs_pkg::PH_P1;
					end
					rprs_pkg::PH_P1: begin
						wait_d = wait_inc;
						if (item_s1.sent_done) begin
							res_d.radio_cmd   = rprs_pkg::CMD_LISTEN;
							res_d.target_node = node_q;
							wait_d  = 8'd0;
							phase_d = rprs_pkg::PH_P2;
						end else if (wait_inc == send_to_q) begin
							res_d.radio_cmd   = rprs_pkg::CMD_REINIT;
							res_d.target_node = node_q;
							wait_d  = 8'd0;
							phase_d = rprs_pkg::PH_P0;
						end else if (item_s1.retry_exhausted) begin
							res_d.radio_cmd   = rprs_pkg::CMD_RETRANSMIT;
							res_d.target_node = node_q;
						end
					end
					rprs_pkg::PH_P2: begin
						wait_d = wait_inc;
						if (item_s1.reply_ready) begin
							rx_wr_en   = 1'b1;
							rx_wr_addr = node_q;
							relay_en   = item_s1.rx_byte_a < 8'(rprs_pkg::NODE_COUNT);
							led_d      = !led_q;
							res_d.radio_cmd   = rprs_pkg::CMD_FETCH;
							res_d.target_node = node_q;
							wait_d  = 8'd0;
							phase_d = rprs_pkg::PH_P0;
						end else if (wait_inc == reply_to_q) begin
							res_d.radio_cmd   = rprs_pkg::CMD_REINIT;
							res_d.target_node = node_q;
							wait_d  = 8'd0;
							phase_d = rprs_pkg::PH_P0;
						end
					end
					default: begin
						phase_d = rprs_pkg::PH_P0;
					end
				endcase
			end else begin
				case (phase_q)
					rprs_pkg::PH_P0: begin
						res_d.radio_cmd   = rprs_pkg::CMD_LISTEN;
						res_d.target_node = own_node_q;
						phase_d = rprs_pkg::PH_P1;
					end
					rprs_pkg::PH_P1: begin
						wait_d = wait_inc;
						if (item_s1.reply_ready) begin
							rx_wr_en   = 1'b1;
							rx_wr_addr = 3'd0;
							res_d.radio_cmd   = rprs_pkg::CMD_FETCH;
							res_d.target_node = own_node_q;
							wait_d  = 8'd0;
							phase_d = rprs_pkg::PH_P2;
						end else if (wait_inc == rprs_pkg::SLAVE_LISTEN_TICKS) begin
							rx_clr = 1'b1;
							res_d.radio_cmd   = rprs_pkg::CMD_REINIT;
							res_d.target_node = own_node_q;
							wait_d  = 8'd0;
							phase_d = rprs_pkg::PH_P0;
						end
					end
					rprs_pkg::PH_P2: begin
						tx_sel = tx_q[0];
						res_d.radio_cmd   = rprs_pkg::CMD_TRANSMIT;
						res_d.target_node = own_node_q;
						phase_d = rprs_pkg::PH_P3;
					end
					default: begin
						wait_d = wait_inc;
						if (item_s1.sent_done) begin
							res_d.radio_cmd   = rprs_pkg::CMD_LISTEN;
							res_d.target_node = own_node_q;
							wait_d  = 8'd0;
							phase_d = rprs_pkg::PH_P1;
						end else if (wait_inc == rprs_pkg::SLAVE_SEND_TICKS) begin
							rx_clr = 1'b1;
							res_d.radio_cmd   = rprs_pkg::CMD_REINIT;
							res_d.target_node = own_node_q;
							wait_d  = 8'd0;
							phase_d = rprs_pkg::PH_P0;
						end else if (item_s1.retry_exhausted) begin
							res_d.radio_cmd   = rprs_pkg::CMD_RETRANSMIT;
							res_d.target_node = own_node_q;
						end
					end
				endcase
			end
		end else if (item_s1.kind == rprs_pkg::KIND_HOST_READ) begin
			if (item_s1.table_index < 3'(rprs_pkg::PAYLOAD_BYTES)) begin
				res_d.read_data = rx_q[item_s1.table_node][item_s1.table_index];
			end
		end

		res_d.tx_byte_a = tx_sel[0];
		res_d.tx_byte_b = tx_sel[1];
		res_d.tx_byte_c = tx_sel[2];
		res_d.tx_byte_d = tx_sel[3];
		res_d.tx_byte_e = tx_sel[4];
		res_d.led_on    = led_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rprs_pkg::PH_P0;
			node_q  <= 3'd0;
			wait_q  <= 8'd0;
			led_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			node_q  <= node_d;
			wait_q  <= wait_d;
			led_q   <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rprs_pkg::TABLE_DEPTH; i++) begin
				tx_q[i] <= '0;
			end
		end else if (advance) begin
			if (host_wr) begin
				tx_q[item_s1.table_node][item_s1.table_index] <= item_s1.table_value;
			end else if (relay_en) begin
				tx_q[item_s1.rx_byte_a[2:0]] <= rx_entry;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rprs_pkg::TABLE_DEPTH; i++) begin
				rx_q[i] <= '0;
			end
		end else if (advance) begin
			if (rx_clr) begin
				for (int i = 0; i < rprs_pkg::TABLE_DEPTH; i++) begin
					rx_q[i] <= '0;
				end
			end else if (rx_wr_en) begin
				rx_q[rx_wr_addr] <= rx_entry;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	a_beat_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result beat not registered");

	a_fetch_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res_d.radio_cmd == rprs_pkg::CMD_FETCH) |=> wait_q == 8'd0)
		else $error("wait count not cleared after fetch");

	a_led_only_on_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res_d.radio_cmd != rprs_pkg::CMD_FETCH) |=> led_q == $past(led_q))
		else $error("led changed without a reply");

	a_poll_node_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !role_q && (item_s1.kind == rprs_pkg::KIND_TICK)
		&& (phase_q == rprs_pkg::PH_P0) |=> node_q != 3'd0)
		else $error("master polled node zero");

endmodule

FILE: tb/radio_poll_relay_sequencer_core_tb.sv
module radio_poll_relay_sequencer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rprs_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	class poll_scoreboard;
		bit       role;
		bit [2:0] own_node;
		bit [7:0] send_limit;
		bit [7:0] reply_limit;
		bit [1:0] seq_phase;
		bit [2:0] cur_node;
		bit [7:0] wait_cnt;
		bit       led;
		bit [7:0] tx_tab [TABLE_DEPTH][PAYLOAD_BYTES];
		bit [7:0] rx_tab [TABLE_DEPTH][PAYLOAD_BYTES];
		bit [7:0] rx_now [PAYLOAD_BYTES];
		result_t  pending [$];
		int       errors;

		function new();
			role = 1'b0;
			own_node = 3'd0;
			send_limit = SEND_TIMEOUT_RESET;
			reply_limit = REPLY_TIMEOUT_RESET;
			seq_phase = 2'd0;
			cur_node = 3'd0;
			wait_cnt = 8'd0;
			led = 1'b0;
			errors = 0;
			foreach (tx_tab[n, j]) begin
				tx_tab[n][j] = 8'd0;
				rx_tab[n][j] = 8'd0;
			end
		endfunction

		function void write_reg(cfg_reg_t idx, bit [7:0] v);
			case (idx)
				REG_ROLE: role = v[0];
				REG_OWN_NODE: own_node = v[2:0];
				REG_SEND_TIMEOUT: send_limit = v;
				REG_REPLY_TIMEOUT: reply_limit = v;
				default: ;
			endcase
		endfunction

		function result_t base(cmd_t cmd, bit [2:0] node);
			result_t r;
			r = '0;
			r.radio_cmd = cmd;
			r.target_node = node;
			r.led_on = led;
			return r;
		endfunction

		function result_t with_entry(bit [2:0] node, int e);
			result_t r;
			r = base(CMD_TRANSMIT, node);
			r.tx_byte_a = tx_tab[e][0];
			r.tx_byte_b = tx_tab[e][1];
			r.tx_byte_c = tx_tab[e][2];
			r.tx_byte_d = tx_tab[e][3];
			r.tx_byte_e = tx_tab[e][4];
			return r;
		endfunction

		function void clear_rx();
			foreach (rx_tab[n, j])
				rx_tab[n][j] = 8'd0;
		endfunction

		function result_t master_tick(bit sent, bit retry, bit rdy);
			result_t r;
			int nxt;
			case (seq_phase)
				2'd0: begin
					nxt = int'(cur_node) + 1;
					if (nxt >= NODE_COUNT)
						nxt = 1;
					cur_node = nxt[2:0];
					r = with_entry(cur_node, int'(cur_node));
					seq_phase = 2'd1;
				end
				2'd1: begin
					wait_cnt++;
					if (sent) begin
						r = base(CMD_LISTEN, cur_node);
						wait_cnt = 8'd0;
						seq_phase = 2'd2;
					end else if (wait_cnt == send_limit) begin
						r = base(CMD_REINIT, cur_node);
						wait_cnt = 8'd0;
						seq_phase = 2'd0;
					end else begin
						r = retry ? base(CMD_RETRANSMIT, cur_node) : base(CMD_NONE, 3'd0);
					end
				end
				2'd2: begin
					wait_cnt++;
					if (rdy) begin
						foreach (rx_now[j])
							rx_tab[cur_node][j] = rx_now[j];
						if (rx_now[0] < NODE_COUNT && rx_now[0] < TABLE_DEPTH)
							foreach (rx_now[j])
								tx_tab[rx_now[0][2:0]][j] = rx_now[j];
						led = ~led;
						r = base(CMD_FETCH, cur_node);
						wait_cnt = 8'd0;
						seq_phase = 2'd0;
					end else if (wait_cnt == reply_limit) begin
						r = base(CMD_REINIT, cur_node);
						wait_cnt = 8'd0;
						seq_phase = 2'd0;
					end else begin
						r = base(CMD_NONE, 3'd0);
					end
				end
				default: begin
					r = base(CMD_NONE, 3'd0);
					seq_phase = 2'd0;
				end
			endcase
			return r;
		endfunction

		function result_t slave_tick(bit sent, bit retry, bit rdy);
			result_t r;
			case (seq_phase)
				2'd0: begin
					r = base(CMD_LISTEN, own_node);
					seq_phase = 2'd1;
				end
				2'd1: begin
					wait_cnt++;
					if (rdy) begin
						foreach (rx_now[j])
							rx_tab[0][j] = rx_now[j];
						r = base(CMD_FETCH, own_node);
						wait_cnt = 8'd0;
						seq_phase = 2'd2;
					end else if (wait_cnt == SLAVE_LISTEN_TICKS) begin
						clear_rx();
						r = base(CMD_REINIT, own_node);
						wait_cnt = 8'd0;
						seq_phase = 2'd0;
					end else begin
						r = base(CMD_NONE, 3'd0);
					end
				end
				2'd2: begin
					r = with_entry(own_node, 0);
					seq_phase = 2'd3;
				end
				default: begin
					wait_cnt++;
					if (sent) begin
						r = base(CMD_LISTEN, own_node);
						wait_cnt = 8'd0;
						seq_phase = 2'd1;
					end else if (wait_cnt == SLAVE_SEND_TICKS) begin
						clear_rx();
						r = base(CMD_REINIT, own_node);
						wait_cnt = 8'd0;
						seq_phase = 2'd0;
					end else begin
						r = retry ? base(CMD_RETRANSMIT, own_node) : base(CMD_NONE, 3'd0);
					end
				end
			endcase
			return r;
		endfunction

		function void note_item(item_t it);
			result_t r;
			rx_now[0] = it.rx_byte_a;
			rx_now[1] = it.rx_byte_b;
			rx_now[2] = it.rx_byte_c;
			rx_now[3] = it.rx_byte_d;
			rx_now[4] = it.rx_byte_e;
			case (it.kind)
				KIND_TICK: begin
					if (role)
						r = slave_tick(it.sent_done, it.retry_exhausted, it.reply_ready);
					else
						r = master_tick(it.sent_done, it.retry_exhausted, it.reply_ready);
				end
				KIND_HOST_WRITE: begin
					if (it.table_index < PAYLOAD_BYTES)
						tx_tab[it.table_node][it.table_index] = it.table_value;
					r = base(CMD_NONE, 3'd0);
				end
				KIND_HOST_READ: begin
					r = base(CMD_NONE, 3'd0);
					if (it.table_index < PAYLOAD_BYTES)
						r.read_data = rx_tab[it.table_node][it.table_index];
				end
				default: r = base(CMD_NONE, 3'd0);
			endcase
			pending.push_back(r);
		endfunction

		function void cmp(string name, logic [7:0] exp_v, logic [7:0] got_v);
			if (exp_v !== got_v) begin
				$error("%s: expected %0d, actual %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("result beat with nothing outstanding: cmd %0d", got.radio_cmd);
				errors++;
				return;
			end
			want = pending.pop_front();
			cmp("radio_cmd", 8'(want.radio_cmd), 8'(got.radio_cmd));
			cmp("target_node", 8'(want.target_node), 8'(got.target_node));
			cmp("tx_byte_a", want.tx_byte_a, got.tx_byte_a);
			cmp("tx_byte_b", want.tx_byte_b, got.tx_byte_b);
			cmp("tx_byte_c", want.tx_byte_c, got.tx_byte_c);
			cmp("tx_byte_d", want.tx_byte_d, got.tx_byte_d);
			cmp("tx_byte_e", want.tx_byte_e, got.tx_byte_e);
			cmp("read_data", want.read_data, got.read_data);
			cmp("led_on", 8'(want.led_on), 8'(got.led_on));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	int         burst_left;

	poll_scoreboard sb = new();

	rprs_item_if item_ch();
	rprs_result_if result_ch();

	radio_poll_relay_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// result checked before the new beat is noted, both on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.payload);
			if (item_ch.valid && item_ch.ready)
				sb.note_item(item_ch.payload);
		end
	end

	// receiver stall pattern
	initial begin
		int mode;
		int left;
		result_ch.ready = 1'b0;
		mode = 0;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 100);
			end
			left--;
			case (mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= ($urandom_range(0, 99) < 70);
				2: result_ch.ready <= (left % 4 != 0);
				default: result_ch.ready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	function automatic item_t tick(bit sent, bit retry, bit rdy, bit [7:0] a = 8'd0,
			bit [7:0] b = 8'd0, bit [7:0] c = 8'd0, bit [7:0] d = 8'd0, bit [7:0] e = 8'd0);
		item_t it;
		it = '0;
		it.kind = KIND_TICK;
		it.sent_done = sent;
		it.retry_exhausted = retry;
		it.reply_ready = rdy;
		it.rx_byte_a = a;
		it.rx_byte_b = b;
		it.rx_byte_c = c;
		it.rx_byte_d = d;
		it.rx_byte_e = e;
		return it;
	endfunction

	function automatic item_t host(logic [1:0] k, bit [2:0] node, bit [2:0] idx,
			bit [7:0] v = 8'd0);
		item_t it;
		it = '0;
		it.kind = k;
		it.table_node = node;
		it.table_index = idx;
		it.table_value = v;
		return it;
	endfunction

	function automatic item_t rand_item(int tick_pct, int flag_pct);
		item_t it;
		int k;
		it = '0;
		k = $urandom_range(0, 99);
		if (k < tick_pct)
			it.kind = KIND_TICK;
		else if (k < tick_pct + (100 - tick_pct) * 45 / 100)
			it.kind = KIND_HOST_WRITE;
		else if (k < tick_pct + (100 - tick_pct) * 90 / 100)
			it.kind = KIND_HOST_READ;
		else
			it.kind = KIND_UNUSED;
		it.sent_done = ($urandom_range(0, 99) < flag_pct);
		it.reply_ready = ($urandom_range(0, 99) < flag_pct);
		it.retry_exhausted = ($urandom_range(0, 99) < 30);
		// relay target mostly a real node
		it.rx_byte_a = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 7))
			: 8'($urandom_range(0, 255));
		it.rx_byte_b = 8'($urandom_range(0, 255));
		it.rx_byte_c = 8'($urandom_range(0, 255));
		it.rx_byte_d = 8'($urandom_range(0, 255));
		it.rx_byte_e = 8'($urandom_range(0, 255));
		it.table_node = 3'($urandom_range(0, 7));
		it.table_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, 4));
		it.table_value = 8'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic send_item(item_t it);
		if (burst_left == 0) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic settle_results();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, bit [7:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(bit r, bit [2:0] own, bit [7:0] send_to, bit [7:0] reply_to,
			int n, int tick_pct, int flag_pct);
		int i;
		settle_results();
		write_reg(REG_ROLE, {7'd0, r});
		write_reg(REG_OWN_NODE, {5'd0, own});
		write_reg(REG_SEND_TIMEOUT, send_to);
		write_reg(REG_REPLY_TIMEOUT, reply_to);
		for (i = 0; i < n; i++) begin
			if (i == n / 2)
				settle_results();
			send_item(rand_item(tick_pct, flag_pct));
		end
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_ROLE;
		cfg_data = 8'd0;
		arst_n = 1'b0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_SEND_TIMEOUT, 8'd2);
		send_item(host(KIND_HOST_WRITE, 3'd1, 3'd0, 8'hFF));
		send_item(host(KIND_HOST_WRITE, 3'd1, 3'd4, 8'h5A));
		send_item(host(KIND_HOST_WRITE, 3'd7, 3'd4, 8'hFF));
		send_item(host(KIND_HOST_WRITE, 3'd1, 3'd7, 8'hAA));
		send_item(host(KIND_UNUSED, 3'd3, 3'd2, 8'hFF));
		send_item(host(KIND_HOST_READ, 3'd0, 3'd0));
		send_item(host(KIND_HOST_READ, 3'd7, 3'd6));
		send_item(tick(1'b0, 1'b0, 1'b0));
		send_item(tick(1'b0, 1'b1, 1'b0));
		send_item(tick(1'b1, 1'b1, 1'b0));
		// relay target out of range
		send_item(tick(1'b0, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(tick(1'b0, 1'b0, 1'b0));
		// timeout and retry together
		send_item(tick(1'b0, 1'b1, 1'b0));
		send_item(tick(1'b0, 1'b1, 1'b0));
		send_item(tick(1'b0, 1'b0, 1'b0));
		send_item(tick(1'b1, 1'b0, 1'b0));
		send_item(tick(1'b0, 1'b0, 1'b1, 8'd1, 8'h11, 8'h22, 8'h33, 8'h44));
		send_item(host(KIND_HOST_READ, 3'd3, 3'd4));
		send_item(tick(1'b0, 1'b0, 1'b0));
		// role change keeps the phase
		settle_results();
		write_reg(REG_ROLE, 8'd1);
		write_reg(REG_OWN_NODE, 8'd5);
		send_item(tick(1'b0, 1'b0, 1'b1, 8'h80, 8'h01, 8'h02, 8'h03, 8'hFE));
		send_item(tick(1'b0, 1'b0, 1'b0));
		// master left in slave phase three
		settle_results();
		write_reg(REG_ROLE, 8'd0);
		send_item(tick(1'b0, 1'b0, 1'b0));
		send_item(host(KIND_HOST_READ, 3'd0, 3'd4));
		send_item(host(KIND_HOST_WRITE, 3'd0, 3'd0, 8'h00));

		run_phase(1'b0, 3'd0, SEND_TIMEOUT_RESET, REPLY_TIMEOUT_RESET, 120, 60, 30);
		run_phase(1'b0, 3'd3, 8'd1, 8'd1, 120, 60, 30);
		run_phase(1'b0, 3'd6, 8'd255, 8'd255, 120, 60, 25);
		run_phase(1'b1, 3'd7, 8'd15, 8'd20, 100, 60, 30);
		// quiet radio: slave listen timeout clears the receive table
		run_phase(1'b1, 3'd0, 8'd1, 8'd255, 240, 85, 0);
		// timeout registers at zero wrap after 256 ticks
		run_phase(1'b0, 3'd2, 8'd0, 8'd0, 290, 90, 0);
		run_phase(1'b0, 3'd4, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
			70, 60, 30);
		run_phase(1'b1, 3'($urandom_range(0, 7)), 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)), 70, 60, 40);

		settle_results();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rprs_pkg.sv
rtl/rprs_item_if.sv
rtl/rprs_result_if.sv
rtl/radio_poll_relay_sequencer_core.sv
tb/radio_poll_relay_sequencer_core_tb.sv
